// File: rtl/shca_pkg.sv
// Shared types, widths and codes of the strip hit cluster accumulator.
package shca_pkg;

    localparam int POS_W    = 18;
    localparam int TIME_W   = 20;
    localparam int PULSE_W  = 12;
    localparam int PACC_W   = 18;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 7;
    localparam int STRIP_W  = 10;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_HITS_DEFAULT = 64;

    localparam logic [1:0] REQ_PROBE = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] VIEW_X    = 2'd0;
    localparam logic [1:0] VIEW_Y    = 2'd1;
    localparam logic [1:0] VIEW_BOTH = 2'd2;
    localparam logic [1:0] VIEW_RSVD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIN    = 2'd2;

    localparam logic [STRIP_W-1:0] STRIP_RESET = 10'd196;
    localparam logic [TIME_W-1:0]  TWIN_RESET  = 20'd99999;

    typedef struct packed {
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

// File: rtl/shca_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module shca_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic        [DIVISOR_W-1:0]  i_divisor,
    output logic signed [DIVIDEND_W-1:0] o_quotient,
    output logic                         o_done
);
    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_count;
    logic [DIVIDEND_W-1:0] r_mag;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic                  r_neg;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;
    logic [DIVISOR_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_mag[DIVIDEND_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= STEP_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude register shifts dividend bits out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);
    assign o_done     = r_done;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("divider done while still busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_count == STEP_W'(DIVIDEND_W - 1))
        else $error("divider did not start a full pass");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_count == '0 && !i_start |=> o_done)
        else $error("divider missed completion");
`endif

endmodule

// File: rtl/shca_ctrl.sv
// Sequencer: accepts a hit, runs the mean dividers, loads the result register.
module shca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output shca_pkg::t_cmd o_cmd,
    input  shca_pkg::t_sts i_sts
);
    import shca_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_load;

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cmd.update    = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.div_start = (r_state == ST_LOAD);
    assign o_cmd.out_load  = w_load;

`ifndef NO_ASSERTIONS
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> r_state == ST_LOAD)
        else $error("accepted transaction did not start division");
    a_rise_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_HOLD)
        else $error("result valid without finished division");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten before taken");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && i_sts.div_done |=> r_state == ST_HOLD)
        else $error("division completion lost");
`endif

endmodule

// File: rtl/shca_dpath.sv
// Cluster state, association test, merge logic, mean dividers and result register.
module shca_dpath #(
    parameter int MAX_HITS = shca_pkg::MAX_HITS_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [shca_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [shca_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  shca_pkg::t_cmd                         i_cmd,
    output shca_pkg::t_sts                         o_sts,
    input  logic [1:0]                             i_req_type,
    input  logic [7:0]                             i_z_plane,
    input  logic                                   i_x_valid,
    input  logic signed [shca_pkg::POS_W-1:0]      i_x_pos,
    input  logic                                   i_y_valid,
    input  logic signed [shca_pkg::POS_W-1:0]      i_y_pos,
    input  logic [shca_pkg::TIME_W-1:0]            i_hit_time,
    input  logic [shca_pkg::PULSE_W-1:0]           i_x_pulse,
    input  logic [shca_pkg::PULSE_W-1:0]           i_y_pulse,
    input  logic [1:0]                             i_hit_view,
    output logic                                   o_associated,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_begin,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_end,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_begin,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_end,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_mean,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_mean,
    output logic [shca_pkg::TIME_W-1:0]            o_time_begin,
    output logic [shca_pkg::TIME_W-1:0]            o_time_end,
    output logic [shca_pkg::PACC_W-1:0]            o_x_pulse_total,
    output logic [shca_pkg::PACC_W-1:0]            o_y_pulse_total,
    output logic [1:0]                             o_cluster_view
);
    import shca_pkg::*;

    localparam int HIT_CAP = (MAX_HITS < 127) ? MAX_HITS : 127;
    localparam int CMP_W   = POS_W + 2;
    localparam int TCMP_W  = TIME_W + 2;
    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W+1)'(1 << (SUM_W-1));
    localparam logic [PACC_W:0] PACC_HI = (PACC_W+1)'((1 << PACC_W) - 1);

    // configuration
    logic [STRIP_W-1:0] r_strip_x;
    logic [STRIP_W-1:0] r_strip_y;
    logic [TIME_W-1:0]  r_twin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_x <= STRIP_RESET;
            r_strip_y <= STRIP_RESET;
            r_twin    <= TWIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STRIP_X: r_strip_x <= i_cfg_wdata[STRIP_W-1:0];
                CFG_STRIP_Y: r_strip_y <= i_cfg_wdata[STRIP_W-1:0];
                CFG_TWIN:    r_twin    <= i_cfg_wdata[TIME_W-1:0];
                default:     ;
            endcase
        end
    end

    // cluster state
    logic [7:0]               r_plane,  n_plane;
    logic signed [POS_W-1:0]  r_x_low,  n_x_low;
    logic signed [POS_W-1:0]  r_x_high, n_x_high;
    logic signed [POS_W-1:0]  r_y_low,  n_y_low;
    logic signed [POS_W-1:0]  r_y_high, n_y_high;
    logic signed [SUM_W-1:0]  r_x_sum,  n_x_sum;
    logic signed [SUM_W-1:0]  r_y_sum,  n_y_sum;
    logic [TIME_W-1:0]        r_t_low,  n_t_low;
    logic [TIME_W-1:0]        r_t_high, n_t_high;
    logic [PACC_W-1:0]        r_x_pacc, n_x_pacc;
    logic [PACC_W-1:0]        r_y_pacc, n_y_pacc;
    logic [1:0]               r_view,   n_view;
    logic [CNT_W-1:0]         r_x_hits, n_x_hits;
    logic [CNT_W-1:0]         r_y_hits, n_y_hits;
    logic [CNT_W-1:0]         r_total,  n_total;
    logic                     r_assoc;

    // association against the cluster as it stands
    logic signed [CMP_W-1:0]  w_mx, w_my, w_xp, w_yp;
    logic signed [TCMP_W-1:0] w_tw, w_t;
    logic                     w_x_ok, w_y_ok, w_t_ok, w_assoc;

    always_comb begin
        w_mx = CMP_W'({r_strip_x, 1'b0});
        w_my = CMP_W'({r_strip_y, 1'b0});
        w_xp = CMP_W'(i_x_pos);
        w_yp = CMP_W'(i_y_pos);
        w_tw = TCMP_W'(r_twin);
        w_t  = TCMP_W'(i_hit_time);
        w_x_ok = !(i_x_valid && r_x_hits != '0) ||
                 (w_xp > CMP_W'(r_x_low) - w_mx && w_xp < CMP_W'(r_x_high) + w_mx);
        w_y_ok = !(i_y_valid && r_y_hits != '0) ||
                 (w_yp > CMP_W'(r_y_low) - w_my && w_yp < CMP_W'(r_y_high) + w_my);
        w_t_ok = (w_t > $signed(TCMP_W'(r_t_low)) - w_tw) &&
                 (w_t < $signed(TCMP_W'(r_t_high)) + w_tw);
        w_assoc = (r_total != '0) && (i_z_plane == r_plane) && w_x_ok && w_y_ok && w_t_ok;
    end

    // merge
    logic [1:0]             w_hv;
    logic signed [SUM_W:0]  w_xs, w_ys;
    logic [PACC_W:0]        w_xpa, w_ypa;

    always_comb begin
        w_hv = (i_hit_view == VIEW_RSVD) ? VIEW_BOTH : i_hit_view;

        n_plane  = r_plane;   n_x_low  = r_x_low;   n_x_high = r_x_high;
        n_y_low  = r_y_low;   n_y_high = r_y_high;  n_x_sum  = r_x_sum;
        n_y_sum  = r_y_sum;   n_t_low  = r_t_low;   n_t_high = r_t_high;
        n_x_pacc = r_x_pacc;  n_y_pacc = r_y_pacc;  n_view   = r_view;
        n_x_hits = r_x_hits;  n_y_hits = r_y_hits;  n_total  = r_total;

        if (i_req_type == REQ_START) begin
            n_plane  = '0;  n_x_low  = '0;  n_x_high = '0;
            n_y_low  = '0;  n_y_high = '0;  n_x_sum  = '0;
            n_y_sum  = '0;  n_t_low  = '0;  n_t_high = '0;
            n_x_pacc = '0;  n_y_pacc = '0;  n_view   = VIEW_BOTH;
            n_x_hits = '0;  n_y_hits = '0;  n_total  = '0;
        end

        w_xs  = (SUM_W+1)'(n_x_sum) + (SUM_W+1)'(i_x_pos);
        w_ys  = (SUM_W+1)'(n_y_sum) + (SUM_W+1)'(i_y_pos);
        w_xpa = (PACC_W+1)'(n_x_pacc) + (PACC_W+1)'(i_x_pulse);
        w_ypa = (PACC_W+1)'(n_y_pacc) + (PACC_W+1)'(i_y_pulse);

        if ((i_req_type == REQ_ADD || i_req_type == REQ_START) &&
            n_total < CNT_W'(HIT_CAP)) begin
            if (n_total == '0) begin
                n_plane  = i_z_plane;
                n_t_low  = i_hit_time;
                n_t_high = i_hit_time;
                n_view   = w_hv;
            end else begin
                if (i_hit_time < n_t_low)  n_t_low  = i_hit_time;
                if (i_hit_time > n_t_high) n_t_high = i_hit_time;
                if (i_x_valid && n_view == VIEW_Y) n_view = VIEW_BOTH;
                if (i_y_valid && n_view == VIEW_X) n_view = VIEW_BOTH;
            end
            if (i_x_valid) begin
                // span opens on the first hit that carries X
                if (n_x_hits == '0 || i_x_pos < n_x_low)  n_x_low  = i_x_pos;
                if (n_x_hits == '0 || i_x_pos > n_x_high) n_x_high = i_x_pos;
                n_x_hits = n_x_hits + 1'b1;
                priority if (w_xs > SUM_HI) n_x_sum = SUM_HI[SUM_W-1:0];
                else if (w_xs < SUM_LO)     n_x_sum = SUM_LO[SUM_W-1:0];
                else                        n_x_sum = w_xs[SUM_W-1:0];
                n_x_pacc = (w_xpa > PACC_HI) ? PACC_HI[PACC_W-1:0] : w_xpa[PACC_W-1:0];
            end
            if (i_y_valid) begin
                if (n_y_hits == '0 || i_y_pos < n_y_low)  n_y_low  = i_y_pos;
                if (n_y_hits == '0 || i_y_pos > n_y_high) n_y_high = i_y_pos;
                n_y_hits = n_y_hits + 1'b1;
                priority if (w_ys > SUM_HI) n_y_sum = SUM_HI[SUM_W-1:0];
                else if (w_ys < SUM_LO)     n_y_sum = SUM_LO[SUM_W-1:0];
                else                        n_y_sum = w_ys[SUM_W-1:0];
                n_y_pacc = (w_ypa > PACC_HI) ? PACC_HI[PACC_W-1:0] : w_ypa[PACC_W-1:0];
            end
            n_total = n_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;  r_x_low  <= '0;  r_x_high <= '0;
            r_y_low  <= '0;  r_y_high <= '0;  r_x_sum  <= '0;
            r_y_sum  <= '0;  r_t_low  <= '0;  r_t_high <= '0;
            r_x_pacc <= '0;  r_y_pacc <= '0;  r_view   <= VIEW_BOTH;
            r_x_hits <= '0;  r_y_hits <= '0;  r_total  <= '0;
        end else if (i_cmd.update) begin
            r_plane  <= n_plane;   r_x_low  <= n_x_low;   r_x_high <= n_x_high;
            r_y_low  <= n_y_low;   r_y_high <= n_y_high;  r_x_sum  <= n_x_sum;
            r_y_sum  <= n_y_sum;   r_t_low  <= n_t_low;   r_t_high <= n_t_high;
            r_x_pacc <= n_x_pacc;  r_y_pacc <= n_y_pacc;  r_view   <= n_view;
            r_x_hits <= n_x_hits;  r_y_hits <= n_y_hits;  r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) r_assoc <= w_assoc;
    end

    // running means
    logic signed [SUM_W-1:0] w_x_quo, w_y_quo;
    logic                    w_x_done, w_y_done;

    shca_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_x_sum),
        .i_divisor  (r_x_hits),
        .o_quotient (w_x_quo),
        .o_done     (w_x_done)
    );

    shca_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(CNT_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_y_sum),
        .i_divisor  (r_y_hits),
        .o_quotient (w_y_quo),
        .o_done     (w_y_done)
    );

    assign o_sts.div_done = w_x_done && w_y_done;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_associated    <= r_assoc;
            o_x_begin       <= r_x_low;
            o_x_end         <= r_x_high;
            o_y_begin       <= r_y_low;
            o_y_end         <= r_y_high;
            o_x_mean        <= (r_x_hits == '0) ? '0 : w_x_quo[POS_W-1:0];
            o_y_mean        <= (r_y_hits == '0) ? '0 : w_y_quo[POS_W-1:0];
            o_time_begin    <= r_t_low;
            o_time_end      <= r_t_high;
            o_x_pulse_total <= r_x_pacc;
            o_y_pulse_total <= r_y_pacc;
            o_cluster_view  <= r_view;
        end
    end

`ifndef NO_ASSERTIONS
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(HIT_CAP))
        else $error("hit count beyond cap");
    a_coord_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_hits <= r_total && r_y_hits <= r_total)
        else $error("coordinate count exceeds hit count");
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_low <= r_x_high && r_y_low <= r_y_high && r_t_low <= r_t_high)
        else $error("cluster span inverted");
`endif

endmodule

// File: rtl/strip_hit_cluster_accumulator.sv
// Top level of the strip hit cluster accumulator.
// Keeps one cluster of strip hits on a single detector plane. Every input transaction
// carries one hit and a request (probe, add, or start a new cluster with the hit);
// association is judged against the cluster as it was before the request; for an add or
// start request below the hit cap the hit is then merged, and one result transaction
// reports the association, the updated spans, position means, pulse totals and view.
// The hit is tested and merged at the accepting edge, then the load state starts the mean
// dividers, the two bit-serial dividers run (one quotient bit per cycle over the 24-bit
// position sums), the sequencer sees both dividers finish, and the output register is
// loaded. The next hit is accepted in the cycle after that load at the earliest, so no new
// hit is taken before the result of the last one is loaded; a result still waiting when
// the next one is ready holds the sequencer until it is taken. The output register lets
// the next hit be accepted while a result still waits. Strip pitches and the time window
// are written over the configuration port; the user must write them only while the block
// is idle, which the block itself does not enforce.
module strip_hit_cluster_accumulator #(
    parameter int MAX_HITS = shca_pkg::MAX_HITS_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [shca_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [shca_pkg::CFG_W-1:0]             i_cfg_wdata,
    // hit channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_req_type,
    input  logic [7:0]                             i_z_plane,
    input  logic                                   i_x_valid,
    input  logic signed [shca_pkg::POS_W-1:0]      i_x_pos,
    input  logic                                   i_y_valid,
    input  logic signed [shca_pkg::POS_W-1:0]      i_y_pos,
    input  logic [shca_pkg::TIME_W-1:0]            i_hit_time,
    input  logic [shca_pkg::PULSE_W-1:0]           i_x_pulse,
    input  logic [shca_pkg::PULSE_W-1:0]           i_y_pulse,
    input  logic [1:0]                             i_hit_view,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_associated,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_begin,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_end,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_begin,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_end,
    output logic signed [shca_pkg::POS_W-1:0]      o_x_mean,
    output logic signed [shca_pkg::POS_W-1:0]      o_y_mean,
    output logic [shca_pkg::TIME_W-1:0]            o_time_begin,
    output logic [shca_pkg::TIME_W-1:0]            o_time_end,
    output logic [shca_pkg::PACC_W-1:0]            o_x_pulse_total,
    output logic [shca_pkg::PACC_W-1:0]            o_y_pulse_total,
    output logic [1:0]                             o_cluster_view
);
    import shca_pkg::*;

    t_cmd w_cmd;   // sequencer commands: merge, start division, load result
    t_sts w_sts;   // datapath status: division finished

    shca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    shca_dpath #(.MAX_HITS(MAX_HITS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (i_req_type),
        .i_z_plane       (i_z_plane),
        .i_x_valid       (i_x_valid),
        .i_x_pos         (i_x_pos),
        .i_y_valid       (i_y_valid),
        .i_y_pos         (i_y_pos),
        .i_hit_time      (i_hit_time),
        .i_x_pulse       (i_x_pulse),
        .i_y_pulse       (i_y_pulse),
        .i_hit_view      (i_hit_view),
        .o_associated    (o_associated),
        .o_x_begin       (o_x_begin),
        .o_x_end         (o_x_end),
        .o_y_begin       (o_y_begin),
        .o_y_end         (o_y_end),
        .o_x_mean        (o_x_mean),
        .o_y_mean        (o_y_mean),
        .o_time_begin    (o_time_begin),
        .o_time_end      (o_time_end),
        .o_x_pulse_total (o_x_pulse_total),
        .o_y_pulse_total (o_y_pulse_total),
        .o_cluster_view  (o_cluster_view)
    );

endmodule
